// ===== rtl/core/hsm_pkg.sv =====
// Shared types and constants for the handle slot map core.
package hsm_pkg;

    localparam int SlotDepthDef    = 64;
    localparam int EntryDepthDef   = 64;
    localparam int PayloadWidthDef = 32;
    localparam int CountWidthDef   = 16;

    localparam logic [2:0] FUNC_ADD     = 3'd0;
    localparam logic [2:0] FUNC_REMOVE  = 3'd1;
    localparam logic [2:0] FUNC_STACK   = 3'd2;
    localparam logic [2:0] FUNC_UNSTACK = 3'd3;
    localparam logic [2:0] FUNC_COMPACT = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the input word
        logic rd_slot;    // read slot store at the latched handle
        logic rd_head;    // read slot store at the free head
        logic rd_entry;   // read entry store at the slot link
        logic do_add;     // perform the add writes
        logic do_mod;     // perform remove, stack or unstack writes
        logic cmp_start;  // reset the compaction pointers
        logic cmp_rd;     // read entry at the read pointer
        logic cmp_step;   // move or skip the entry just read
        logic cmp_done;   // commit the new entry count
        logic finish;     // load the result register
    } hsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] func;
        logic       cmp_last;  // read pointer has reached the entry count
    } hsm_stat_t;

endpackage

// ===== rtl/core/hsm_ctrl.sv =====
// Controller state machine for the handle slot map core.
module hsm_ctrl
    import hsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  hsm_stat_t stat,
    output hsm_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD1   = 8'b0000_0010,
        S_RD2   = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_CRD   = 8'b0001_0000,
        S_CSTEP = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Accept a new word once the last result has been taken or is leaving.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                if (stat.func == FUNC_COMPACT)
                begin
                    cmd.cmp_start = 1'b1;
                    state_next    = S_CRD;
                end
                else
                begin
                    cmd.rd_slot = 1'b1;
                    cmd.rd_head = 1'b1;
                    state_next  = S_RD2;
                end
            end
            S_RD2:
            begin
                cmd.rd_entry = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.func == FUNC_ADD)
                begin
                    cmd.do_add = 1'b1;
                end
                else
                begin
                    cmd.do_mod = 1'b1;
                end
                // The result is taken from the state seen before the writes.
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_CRD:
            begin
                if (stat.cmp_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.cmp_rd = 1'b1;
                    state_next = S_CSTEP;
                end
            end
            S_CSTEP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = S_CRD;
            end
            S_DONE:
            begin
                cmd.cmp_done = 1'b1;
                cmd.finish   = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is only loaded while the output register is free.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !out_valid_reg)
        else $error("result loaded over a pending word");
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("accept outside idle");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (state_reg == S_OUT))
        else $error("compaction did not finish");

endmodule

// ===== rtl/core/hsm_datapath.sv =====
// Slot store, entry store and result register of the handle slot map core.
module hsm_datapath
    import hsm_pkg::*;
#(
    parameter int SLOT_DEPTH    = SlotDepthDef,
    parameter int ENTRY_DEPTH   = EntryDepthDef,
    parameter int PAYLOAD_WIDTH = PayloadWidthDef,
    parameter int COUNT_WIDTH   = CountWidthDef
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hsm_cmd_t                 cmd,
    output hsm_stat_t                stat,
    input  logic [2:0]               func,
    input  logic [5:0]               handle_in,
    input  logic [PAYLOAD_WIDTH-1:0] payload,
    output logic [5:0]               handle_out,
    output logic [15:0]              count_after,
    output logic [1:0]               status,
    output logic [6:0]               entries_in_use
);

    localparam int SW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int EW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int SCW = $clog2(SLOT_DEPTH + 1);
    localparam int ECW = $clog2(ENTRY_DEPTH + 1);
    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
    localparam logic [SCW-1:0] SlotFull = SCW'(SLOT_DEPTH);
    localparam logic [ECW-1:0] EntryFull = ECW'(ENTRY_DEPTH);

    // Memories.
    logic [EW-1:0]            slot_link_mem [SLOT_DEPTH];
    logic [SW-1:0]            slot_next_mem [SLOT_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_mem       [ENTRY_DEPTH];
    logic [COUNT_WIDTH-1:0]   stk_mem       [ENTRY_DEPTH];
    logic [SW-1:0]            own_mem       [ENTRY_DEPTH];
    logic [SLOT_DEPTH-1:0]    live_reg;

    logic [2:0]               func_reg;
    logic [5:0]               hin_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [SCW-1:0]           free_head_reg;
    logic [SCW-1:0]           slots_used_reg;
    logic [ECW-1:0]           entries_used_reg;
    logic [EW-1:0]            link_rd_reg;
    logic [SW-1:0]            head_next_rd_reg;
    logic [COUNT_WIDTH-1:0]   stk_rd_reg;
    logic                     ok_reg;
    logic [ECW-1:0]           rptr_reg;
    logic [ECW-1:0]           wptr_reg;
    logic [PAYLOAD_WIDTH-1:0] cpay_reg;
    logic [COUNT_WIDTH-1:0]   cstk_reg;
    logic [SW-1:0]            cown_reg;
    logic [5:0]               hout_reg;
    logic [COUNT_WIDTH-1:0]   cnt_reg;
    logic [1:0]               st_reg;

    logic                     hd_free;
    logic                     have_slot;
    logic                     add_ok;
    logic [SW-1:0]            add_slot;
    logic [SW-1:0]            h_idx;
    logic [SW-1:0]            head_idx;
    logic [COUNT_WIDTH-1:0]   mod_cnt;
    logic                     mod_free;
    logic [SW-1:0]            link_val;
    logic [1:0]               res_st;
    logic [5:0]               res_h;
    logic [COUNT_WIDTH-1:0]   res_cnt;
    logic                     h_fits;
    logic                     is_mod;

    assign stat.func     = func_reg;
    assign stat.cmp_last = (rptr_reg >= entries_used_reg);

    assign h_fits   = (SCW'(hin_reg) < slots_used_reg) && ({26'd0, hin_reg} < SLOT_DEPTH);
    assign h_idx    = SW'(hin_reg);
    assign head_idx = free_head_reg[SW-1:0];
    assign hd_free  = (free_head_reg < SlotFull);
    assign have_slot = hd_free || (slots_used_reg < SlotFull);
    assign add_ok   = have_slot && (entries_used_reg < EntryFull);
    assign add_slot = hd_free ? head_idx : slots_used_reg[SW-1:0];

    // Only remove, stack and unstack touch the addressed entry.
    assign is_mod = (func_reg == FUNC_REMOVE) || (func_reg == FUNC_STACK)
                    || (func_reg == FUNC_UNSTACK);

    // Count after remove, stack or unstack.
    always_comb
    begin
        mod_cnt  = '0;
        mod_free = 1'b0;
        case (func_reg)
            FUNC_REMOVE:
            begin
                mod_free = 1'b1;
            end
            FUNC_STACK:
            begin
                mod_cnt = (stk_rd_reg < CountMax) ? stk_rd_reg + 1'b1 : stk_rd_reg;
            end
            default:
            begin
                mod_cnt  = (stk_rd_reg > 0) ? stk_rd_reg - 1'b1 : stk_rd_reg;
                mod_free = (mod_cnt == 0);
            end
        endcase
        link_val = hd_free ? head_idx : h_idx;
    end

    // Result selection.
    always_comb
    begin
        res_h   = hin_reg;
        res_cnt = '0;
        res_st  = ST_OK;
        case (func_reg)
            FUNC_ADD:
            begin
                if (add_ok)
                begin
                    res_h   = 6'(add_slot);
                    res_cnt = COUNT_WIDTH'(1);
                end
                else
                begin
                    res_h  = '0;
                    res_st = ST_FULL;
                end
            end
            FUNC_REMOVE, FUNC_STACK, FUNC_UNSTACK:
            begin
                if (!ok_reg)
                begin
                    res_st = ST_BAD;
                end
                else
                begin
                    res_cnt = mod_cnt;
                end
            end
            FUNC_COMPACT:
            begin
                res_st = ST_OK;
            end
            default:
            begin
                res_st = ST_BAD;
            end
        endcase
    end

    // Memory reads and writes.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= func;
            hin_reg  <= handle_in;
            pay_reg  <= payload;
        end
        if (cmd.rd_slot)
        begin
            link_rd_reg <= slot_link_mem[h_idx];
            ok_reg      <= h_fits && live_reg[h_idx];
        end
        if (cmd.rd_head)
        begin
            head_next_rd_reg <= slot_next_mem[head_idx];
        end
        if (cmd.rd_entry)
        begin
            stk_rd_reg <= stk_mem[link_rd_reg];
        end
        if (cmd.do_add && add_ok)
        begin
            slot_link_mem[add_slot]           <= entries_used_reg[EW-1:0];
            pay_mem[entries_used_reg[EW-1:0]] <= pay_reg;
            stk_mem[entries_used_reg[EW-1:0]] <= COUNT_WIDTH'(1);
            own_mem[entries_used_reg[EW-1:0]] <= add_slot;
        end
        if (cmd.do_mod && ok_reg && is_mod)
        begin
            stk_mem[link_rd_reg] <= mod_cnt;
            if (mod_free)
            begin
                slot_next_mem[h_idx] <= link_val;
            end
        end
        if (cmd.cmp_rd)
        begin
            cpay_reg <= pay_mem[rptr_reg[EW-1:0]];
            cstk_reg <= stk_mem[rptr_reg[EW-1:0]];
            cown_reg <= own_mem[rptr_reg[EW-1:0]];
        end
        if (cmd.cmp_step && cstk_reg != 0 && wptr_reg != rptr_reg - 1'b1)
        begin
            pay_mem[wptr_reg[EW-1:0]]  <= cpay_reg;
            stk_mem[wptr_reg[EW-1:0]]  <= cstk_reg;
            own_mem[wptr_reg[EW-1:0]]  <= cown_reg;
            slot_link_mem[cown_reg]    <= wptr_reg[EW-1:0];
        end
        if (cmd.finish)
        begin
            hout_reg <= res_h;
            cnt_reg  <= res_cnt;
            st_reg   <= res_st;
        end
    end

    // Control registers of the stores.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg         <= '0;
            free_head_reg    <= SlotFull;
            slots_used_reg   <= '0;
            entries_used_reg <= '0;
            rptr_reg         <= '0;
            wptr_reg         <= '0;
        end
        else
        begin
            if (cmd.do_add && add_ok)
            begin
                live_reg[add_slot] <= 1'b1;
                entries_used_reg   <= entries_used_reg + 1'b1;
                if (hd_free)
                begin
                    free_head_reg <= (head_next_rd_reg == head_idx) ? SlotFull
                                                                    : SCW'(head_next_rd_reg);
                end
                else
                begin
                    slots_used_reg <= slots_used_reg + 1'b1;
                end
            end
            if (cmd.do_mod && ok_reg && is_mod && mod_free)
            begin
                live_reg[h_idx] <= 1'b0;
                free_head_reg   <= SCW'(h_idx);
            end
            if (cmd.cmp_start)
            begin
                rptr_reg <= '0;
                wptr_reg <= '0;
            end
            if (cmd.cmp_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (cmd.cmp_step && cstk_reg != 0)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (cmd.cmp_done)
            begin
                entries_used_reg <= wptr_reg;
            end
        end
    end

    assign handle_out     = hout_reg;
    assign count_after    = 16'(cnt_reg);
    assign status         = st_reg;
    assign entries_in_use = 7'(entries_used_reg);

    // Store invariants.
    a_wptr: assert property (@(posedge clk) disable iff (!rst_n)
        wptr_reg <= rptr_reg)
        else $error("compaction write pointer passed read pointer");
    a_entries: assert property (@(posedge clk) disable iff (!rst_n)
        entries_used_reg <= EntryFull)
        else $error("entry count overflow");
    a_slots: assert property (@(posedge clk) disable iff (!rst_n)
        slots_used_reg <= SlotFull)
        else $error("slot count overflow");

endmodule

// ===== rtl/core/handle_slot_map_with_stack_counts_core.sv =====
// Top level of the handle slot map core with per-entry stack counts.
//
// One input word carries func, handle_in and payload; each word gives exactly
// one result word with handle_out, count_after, status and entries_in_use.
// Both channels use valid/ready and a word moves when both are high.
// Add, remove, stack and unstack raise the result valid after the input word
// is accepted, in these steps: two store reads, one read-modify-write that
// also loads the result register, and a last step to raise valid. The next
// word can be accepted once that result leaves. Compact walks the occupied
// entry positions, each read and then moved or skipped through the single
// entry port, and then commits the new entry count before its result is
// valid. One word is in work at a time.
// The result register holds its word while the receiver stalls; a new input
// word is taken as soon as that result leaves. Reset clears the live bits,
// the free list head and the counters; the stores need no clearing.
module handle_slot_map_with_stack_counts_core
    import hsm_pkg::*;
#(
    parameter int SLOT_DEPTH    = SlotDepthDef,
    parameter int ENTRY_DEPTH   = EntryDepthDef,
    parameter int PAYLOAD_WIDTH = PayloadWidthDef,
    parameter int COUNT_WIDTH   = CountWidthDef
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               func,
    input  logic [5:0]               handle_in,
    input  logic [PAYLOAD_WIDTH-1:0] payload,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [5:0]               handle_out,
    output logic [15:0]              count_after,
    output logic [1:0]               status,
    output logic [6:0]               entries_in_use
);

    hsm_cmd_t  cmd;
    hsm_stat_t stat;

    hsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hsm_datapath #(
        .SLOT_DEPTH    (SLOT_DEPTH),
        .ENTRY_DEPTH   (ENTRY_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .func           (func),
        .handle_in      (handle_in),
        .payload        (payload),
        .handle_out     (handle_out),
        .count_after    (count_after),
        .status         (status),
        .entries_in_use (entries_in_use)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the handle slot map core with stack counts.
`timescale 1ns / 1ps

module testbench;
    import hsm_pkg::*;

    localparam int NUM_SLOTS    = 64;
    localparam int NUM_ENTRIES  = 64;
    localparam int COUNT_CEIL   = 65535;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 4 + 2 * NUM_ENTRIES + 20;
    localparam int RANDOM_ITEMS = 1550;
    localparam int STACK_RUN    = 100;

    typedef struct {
        logic [2:0]  func;
        logic [5:0]  handle;
        logic [31:0] payload;
    } table_op_t;

    typedef struct {
        logic [5:0]  handle;
        logic [15:0] count;
        logic [1:0]  status;
        logic [6:0]  in_use;
    } table_reply_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [5:0]  handle_in;
    logic [31:0] payload;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  handle_out;
    logic [15:0] count_after;
    logic [1:0]  status;
    logic [6:0]  entries_in_use;

    table_op_t    pending_ops[$];
    table_reply_t expected_replies[$];
    int           errors;
    int           cycle_count;
    bit           calm;

    // Shadow copy of the handle table.
    logic [5:0]  sh_link[NUM_SLOTS];
    bit          sh_live[NUM_SLOTS];
    logic [31:0] sh_payload[NUM_ENTRIES];
    int          sh_stack[NUM_ENTRIES];
    logic [5:0]  sh_owner[NUM_ENTRIES];
    int          sh_free_head;
    int          sh_slots_used;
    int          sh_entries_used;

    handle_slot_map_with_stack_counts_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .handle_in      (handle_in),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .handle_out     (handle_out),
        .count_after    (count_after),
        .status         (status),
        .entries_in_use (entries_in_use)
    );

    // Return a handle to the free list; the tail links to itself.
    task automatic release_handle(input int h);
        begin
            sh_link[h] = (sh_free_head >= NUM_SLOTS) ? h[5:0] : sh_free_head[5:0];
            sh_free_head = h;
            sh_live[h] = 0;
        end
    endtask

    // Apply one word to the shadow table and return the reply it should give.
    task automatic apply_table_op(input table_op_t op, output table_reply_t rep);
        int  h;
        int  s;
        int  e;
        int  w;
        bit  have_slot;
        begin
            h = op.handle;
            rep.handle = op.handle;
            rep.count = '0;
            rep.status = ST_OK;
            if (op.func == FUNC_ADD) begin
                have_slot = (sh_free_head < NUM_SLOTS) || (sh_slots_used < NUM_SLOTS);
                if (!have_slot || sh_entries_used >= NUM_ENTRIES) begin
                    rep.status = ST_FULL;
                    rep.handle = '0;
                end
                else begin
                    e = sh_entries_used;
                    if (sh_free_head < NUM_SLOTS) begin
                        s = sh_free_head;
                        sh_free_head = (sh_link[s] == s[5:0]) ? NUM_SLOTS : sh_link[s];
                    end
                    else begin
                        s = sh_slots_used;
                        sh_slots_used++;
                    end
                    sh_link[s] = e[5:0];
                    sh_live[s] = 1;
                    sh_payload[e] = op.payload;
                    sh_stack[e] = 1;
                    sh_owner[e] = s[5:0];
                    sh_entries_used++;
                    rep.handle = s[5:0];
                    rep.count = 16'd1;
                end
            end
            else if (op.func == FUNC_REMOVE || op.func == FUNC_STACK
                     || op.func == FUNC_UNSTACK) begin
                if (!(h < sh_slots_used && sh_live[h])) begin
                    rep.status = ST_BAD;
                end
                else begin
                    e = sh_link[h];
                    if (op.func == FUNC_REMOVE) begin
                        sh_stack[e] = 0;
                        release_handle(h);
                    end
                    else if (op.func == FUNC_STACK) begin
                        if (sh_stack[e] < COUNT_CEIL)
                            sh_stack[e]++;
                        rep.count = sh_stack[e][15:0];
                    end
                    else begin
                        if (sh_stack[e] > 0)
                            sh_stack[e]--;
                        if (sh_stack[e] == 0)
                            release_handle(h);
                        rep.count = sh_stack[e][15:0];
                    end
                end
            end
            else if (op.func == FUNC_COMPACT) begin
                w = 0;
                for (int r = 0; r < sh_entries_used; r++) begin
                    if (sh_stack[r] > 0) begin
                        if (w != r) begin
                            sh_payload[w] = sh_payload[r];
                            sh_stack[w] = sh_stack[r];
                            sh_owner[w] = sh_owner[r];
                            sh_link[sh_owner[w]] = w[5:0];
                        end
                        w++;
                    end
                end
                sh_entries_used = w;
            end
            else begin
                rep.status = ST_BAD;
            end
            rep.in_use = sh_entries_used[6:0];
        end
    endtask

    task automatic queue_op(input logic [2:0] f, input logic [5:0] h, input logic [31:0] p);
        table_op_t op;
        begin
            op.func = f;
            op.handle = h;
            op.payload = p;
            pending_ops = {pending_ops, op};
        end
    endtask

    // Wait until every queued word has been sent and answered.
    task automatic wait_drained();
        begin
            while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0)
                @(posedge clk);
        end
    endtask

    // Clock and reset.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Driver: one word in flight on the input channel.
    always @(posedge clk or negedge rst_n)
    begin
        table_op_t    op;
        table_reply_t rep;
        if (!rst_n)
        begin
            in_valid <= 0;
            func <= 0;
            handle_in <= 0;
            payload <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                op.func = func;
                op.handle = handle_in;
                op.payload = payload;
                apply_table_op(op, rep);
                expected_replies = {expected_replies, rep};
            end
            if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 26))
            begin
                op = pending_ops.pop_front();
                func <= op.func;
                handle_in <= op.handle;
                payload <= op.payload;
                in_valid <= 1;
            end
            else
                in_valid <= 0;
        end
    end

    // Monitor: random backpressure and reply checking.
    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t want;
        if (!rst_n)
            out_ready <= 0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply word handle %0d", $time, handle_out);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (handle_out !== want.handle)
                    begin
                        $display("%0t: handle_out expected %0d actual %0d",
                                 $time, want.handle, handle_out);
                        errors++;
                    end
                    if (count_after !== want.count)
                    begin
                        $display("%0t: count_after expected %0d actual %0d",
                                 $time, want.count, count_after);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        errors++;
                    end
                    if (entries_in_use !== want.in_use)
                    begin
                        $display("%0t: entries_in_use expected %0d actual %0d",
                                 $time, want.in_use, entries_in_use);
                        errors++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    // Stimulus sequence.
    initial
    begin
        int span;
        int pick;
        logic [2:0] f;
        errors = 0;
        cycle_count = 0;
        calm = 0;
        sh_free_head = NUM_SLOTS;
        sh_slots_used = 0;
        sh_entries_used = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            sh_live[i] = 0;
        @(posedge rst_n);

        // Directed: extremes, each operation, bad handles, unknown codes, reuse order.
        queue_op(FUNC_ADD, 6'd0, 32'h0000_0000);
        queue_op(FUNC_ADD, 6'd63, 32'hFFFF_FFFF);
        queue_op(FUNC_STACK, 6'd0, 32'h0);
        queue_op(FUNC_UNSTACK, 6'd1, 32'h0);
        queue_op(FUNC_UNSTACK, 6'd1, 32'h0);
        queue_op(FUNC_STACK, 6'd63, 32'h0);
        queue_op(FUNC_REMOVE, 6'd0, 32'h0);
        queue_op(FUNC_REMOVE, 6'd0, 32'h0);
        queue_op(3'd5, 6'd21, 32'h0);
        queue_op(3'd6, 6'd42, 32'h0);
        queue_op(3'd7, 6'd63, 32'hFFFF_FFFF);
        queue_op(FUNC_COMPACT, 6'd63, 32'h0);
        queue_op(FUNC_ADD, 6'd0, 32'hA5A5_5A5A);
        queue_op(FUNC_ADD, 6'd0, 32'h5A5A_A5A5);
        queue_op(FUNC_ADD, 6'd0, 32'h1234_5678);
        queue_op(FUNC_COMPACT, 6'd0, 32'h0);
        wait_drained();

        // Fill the table, then hit the full cases for both handles and entries.
        for (int i = 0; i < NUM_SLOTS + 2; i++)
            queue_op(FUNC_ADD, 6'd0, $urandom);
        queue_op(FUNC_REMOVE, 6'd5, 32'h0);
        queue_op(FUNC_ADD, 6'd0, 32'h0);
        queue_op(FUNC_COMPACT, 6'd0, 32'h0);
        queue_op(FUNC_ADD, 6'd0, 32'hDEAD_BEEF);
        queue_op(FUNC_ADD, 6'd0, 32'h0);
        for (int i = 0; i < NUM_SLOTS; i++)
            queue_op(FUNC_REMOVE, i[5:0], 32'h0);
        queue_op(FUNC_COMPACT, 6'd0, 32'h0);
        wait_drained();

        // Drive one count well up, step it down once, then remove it.
        calm = 1;
        queue_op(FUNC_ADD, 6'd0, 32'hCAFE_F00D);
        wait_drained();
        for (int i = 0; i < STACK_RUN; i++)
            queue_op(FUNC_STACK, 6'd0, 32'h0);
        queue_op(FUNC_UNSTACK, 6'd0, 32'h0);
        queue_op(FUNC_REMOVE, 6'd0, 32'h0);
        queue_op(FUNC_COMPACT, 6'd0, 32'h0);
        wait_drained();
        calm = 0;

        // Random traffic, weighted toward valid handles, drained halfway.
        span = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                f = FUNC_ADD;
            else if (pick < 40)
                f = FUNC_REMOVE;
            else if (pick < 65)
                f = FUNC_STACK;
            else if (pick < 86)
                f = FUNC_UNSTACK;
            else if (pick < 95)
                f = FUNC_COMPACT;
            else
                f = 3'($urandom_range(5, 7));
            if (f == FUNC_ADD && span < NUM_SLOTS - 1)
                span++;
            if ($urandom_range(0, 9) == 0)
                queue_op(f, 6'($urandom_range(0, 63)), $urandom);
            else
                queue_op(f, 6'($urandom_range(0, span)), $urandom);
            if (i == RANDOM_ITEMS / 2)
            begin
                wait_drained();
                calm = 1;
            end
            if (i == RANDOM_ITEMS / 2 + 300)
                calm = 0;
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
